// ===== hw/rtl/gcab_pkg.sv =====
// ----------------------------------------------------------------------------
// Gradient checker alpha blend: shared package
// Register indexes, reset values, operation codes, coefficient sequencer
// states and the gradient step bundle used by the top level and the
// coefficient unit.
// ----------------------------------------------------------------------------
package gcab_pkg;

	// Default sizes of the colour map and of the widest bar.
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int MAX_WIDTH_DEF   = 4096;

	// Fixed field widths.
	localparam int WIDTH_W = 13;
	localparam int COL_W   = 12;
	localparam int REG_W   = 32;
	localparam int IDX_W   = 3;

	// Width of one signed 16.16 gradient step kept modulo 2^24.
	localparam int STEP_W = 24;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_START_COLOR = 3'd0;
	localparam logic [IDX_W-1:0] REG_MID_COLOR   = 3'd1;
	localparam logic [IDX_W-1:0] REG_END_COLOR   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DARK_LEVEL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIGHT_LEVEL = 3'd4;
	localparam logic [IDX_W-1:0] REG_CHECK_MASK  = 3'd5;
	localparam logic [IDX_W-1:0] REG_AREA_WIDTH  = 3'd6;
	localparam logic [IDX_W-1:0] REG_USE_MAP     = 3'd7;

	// Register reset values.
	localparam logic [31:0]        RST_START_COLOR = 32'h0000_00ff;
	localparam logic [31:0]        RST_MID_COLOR   = 32'hff00_00ff;
	localparam logic [31:0]        RST_END_COLOR   = 32'hffff_ffff;
	localparam logic [7:0]         RST_DARK_LEVEL  = 8'h5f;
	localparam logic [7:0]         RST_LIGHT_LEVEL = 8'ha0;
	localparam logic [7:0]         RST_CHECK_MASK  = 8'h08;
	localparam logic [WIDTH_W-1:0] RST_AREA_WIDTH  = 13'd96;
	localparam logic               RST_USE_MAP     = 1'b0;

	// Input operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// Rounding constant of the blend.
	localparam logic [15:0] BLEND_ROUND = 16'h0080;

	// Divider jobs: four channels of each half, then the map step.
	localparam logic [3:0] JOB_MAP = 4'd8;

	// Coefficient sequencer states.
	typedef enum logic [1:0] {
		CS_LOAD,
		CS_RUN,
		CS_STORE,
		CS_DONE
	} coef_state_t;

	// Per-channel gradient steps for the left and the right half.
	typedef struct packed {
		logic [3:0][STEP_W-1:0] lo;
		logic [3:0][STEP_W-1:0] hi;
	} grad_step_t;

	// Byte of an RGBA word: red first, alpha last.
	function automatic logic [7:0] byte_of(input logic [31:0] rgba, input logic [1:0] ch);
		logic [7:0] b;
		case (ch)
			2'd0:    b = rgba[31:24];
			2'd1:    b = rgba[23:16];
			2'd2:    b = rgba[15:8];
			default: b = rgba[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/gcab_coef.sv =====
// ----------------------------------------------------------------------------
// Gradient checker alpha blend: coefficient unit
// Works out the eight gradient steps and the map step with one shared
// restoring divider, one quotient bit per cycle, after reset and after
// every configuration write.
// ----------------------------------------------------------------------------
module gcab_coef #(
	parameter int TABLE_DEPTH = gcab_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int SW = AW + 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [31:0]                  start_color,
	input  logic [31:0]                  mid_color,
	input  logic [31:0]                  end_color,
	input  logic [gcab_pkg::WIDTH_W-1:0] width,
	output gcab_pkg::grad_step_t         grad,
	output logic [SW-1:0]                map_step,
	output logic                         ready
);

	localparam int WW = gcab_pkg::WIDTH_W;
	localparam int NW = (AW + 17 > 24) ? AW + 17 : 24;
	localparam int CW = $clog2(NW);
	localparam logic [NW-1:0] MAP_NUM = NW'(TABLE_DEPTH) << 16;

	gcab_pkg::coef_state_t state_q, state_d;
	logic [3:0]    job_q;
	logic [CW-1:0] cnt_q;

	logic load_en, run_en, store_en;

	logic [NW-1:0] num_q;
	logic [WW-1:0] rem_q;
	logic [WW-1:0] den_q;
	logic [3:0][gcab_pkg::STEP_W-1:0] lo_q, hi_q;
	logic [SW-1:0] map_step_q;

	logic [31:0]   from_c, to_c;
	logic [7:0]    a_c, b_c, mag_c;
	logic          neg_c;
	logic [NW-1:0] num_c;
	logic [WW-1:0] den_c;
	logic [WW:0]   trial_c, diff_c;
	logic          ge_c;
	logic [gcab_pkg::STEP_W-1:0] q_c, step_c;

	// Next state of the sequencer; a configuration write starts over.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gcab_pkg::CS_LOAD:  state_d = gcab_pkg::CS_RUN;
			gcab_pkg::CS_RUN:   state_d = (cnt_q == '0) ? gcab_pkg::CS_STORE : gcab_pkg::CS_RUN;
			gcab_pkg::CS_STORE: begin
				state_d = (job_q == gcab_pkg::JOB_MAP) ? gcab_pkg::CS_DONE : gcab_pkg::CS_LOAD;
			end
			gcab_pkg::CS_DONE:  state_d = gcab_pkg::CS_DONE;
			default:            state_d = gcab_pkg::CS_LOAD;
		endcase
		if (restart) begin
			state_d = gcab_pkg::CS_LOAD;
		end
	end

	// Sequencer outputs.
	always_comb begin
		load_en  = 1'b0;
		run_en   = 1'b0;
		store_en = 1'b0;
		ready    = 1'b0;
		case (state_q)
			gcab_pkg::CS_LOAD:  load_en  = 1'b1;
			gcab_pkg::CS_RUN:   run_en   = 1'b1;
			gcab_pkg::CS_STORE: store_en = 1'b1;
			gcab_pkg::CS_DONE:  ready    = 1'b1;
			default:            ready    = 1'b0;
		endcase
	end

	// Sequencer registers: state, job number and bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcab_pkg::CS_LOAD;
			job_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				job_q <= '0;
			end else if (store_en && job_q != gcab_pkg::JOB_MAP) begin
				job_q <= job_q + 4'd1;
			end
			if (load_en) begin
				cnt_q <= CW'(NW - 1);
			end else if (run_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Operands of the current job. Gradient jobs divide the 16.16 colour
	// difference magnitude by half the width; the map job divides the
	// scaled table depth by the width.
	always_comb begin
		from_c = job_q[2] ? mid_color : start_color;
		to_c   = job_q[2] ? end_color : mid_color;
		a_c    = gcab_pkg::byte_of(from_c, job_q[1:0]);
		b_c    = gcab_pkg::byte_of(to_c, job_q[1:0]);
		neg_c  = (b_c < a_c);
		mag_c  = neg_c ? (a_c - b_c) : (b_c - a_c);
		if (job_q == gcab_pkg::JOB_MAP) begin
			num_c = MAP_NUM;
			den_c = width;
		end else begin
			num_c = NW'({mag_c, 16'h0000});
			den_c = {1'b0, width[WW-1:1]};
		end
	end

	// One restoring step and the signed step that truncates toward zero.
	always_comb begin
		trial_c = {rem_q, num_q[NW-1]};
		diff_c  = trial_c - {1'b0, den_q};
		ge_c    = (trial_c >= {1'b0, den_q});
		q_c     = num_q[gcab_pkg::STEP_W-1:0];
		step_c  = neg_c ? (~q_c + gcab_pkg::STEP_W'(1)) : q_c;
	end

	// Divider datapath and result registers.
	always_ff @(posedge clk) begin
		if (load_en) begin
			num_q <= num_c;
			rem_q <= '0;
			den_q <= den_c;
		end else if (run_en) begin
			num_q <= {num_q[NW-2:0], ge_c};
			rem_q <= ge_c ? diff_c[WW-1:0] : trial_c[WW-1:0];
		end
		if (store_en) begin
			if (job_q == gcab_pkg::JOB_MAP) begin
				map_step_q <= SW'(num_q);
			end else if (job_q[2]) begin
				hi_q[job_q[1:0]] <= step_c;
			end else begin
				lo_q[job_q[1:0]] <= step_c;
			end
		end
	end

	assign grad.lo  = lo_q;
	assign grad.hi  = hi_q;
	assign map_step = map_step_q;

endmodule

// ===== hw/rtl/gradient_checker_alpha_blend.sv =====
// An input transfer passes the stage 1 to 4 registers to the output register.
// Throughput: one item per cycle while the output is taken and the steps are
// ready; stages fill bubbles while the output waits. After reset and after
// every configuration write the input is not ready until the shared serial
// divider has worked out the steps.
// Reset: valid and config registers clear at once; data and colour map do not.
// ----------------------------------------------------------------------------
// Gradient checker alpha blend: top level
// Colour bar pixels from a three-colour gradient or a loaded colour map,
// alpha blended over a grey checkerboard, in a five-stage pipeline.
// ----------------------------------------------------------------------------
module gradient_checker_alpha_blend #(
	parameter int TABLE_DEPTH = gcab_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_WIDTH   = gcab_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [gcab_pkg::IDX_W-1:0]   cfg_index,
	input  logic [gcab_pkg::REG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [gcab_pkg::COL_W-1:0]   column,
	input  logic [gcab_pkg::COL_W-1:0]   row,
	input  logic [9:0]                   entry_index,
	input  logic [31:0]                  entry_rgba,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic                         width_error
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int SW  = AW + 16;
	localparam int CLW = gcab_pkg::COL_W;
	localparam int WW  = gcab_pkg::WIDTH_W;
	localparam int PHW = CLW + AW;
	localparam int PLW = CLW + 16;
	localparam int TW  = gcab_pkg::STEP_W;

	// Configuration registers.
	logic [31:0]   start_color_q, mid_color_q, end_color_q;
	logic [7:0]    dark_level_q, light_level_q, check_mask_q;
	logic [WW-1:0] area_width_q;
	logic          use_map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= gcab_pkg::RST_START_COLOR;
			mid_color_q   <= gcab_pkg::RST_MID_COLOR;
			end_color_q   <= gcab_pkg::RST_END_COLOR;
			dark_level_q  <= gcab_pkg::RST_DARK_LEVEL;
			light_level_q <= gcab_pkg::RST_LIGHT_LEVEL;
			check_mask_q  <= gcab_pkg::RST_CHECK_MASK;
			area_width_q  <= gcab_pkg::RST_AREA_WIDTH;
			use_map_q     <= gcab_pkg::RST_USE_MAP;
		end else if (cfg_write) begin
			case (cfg_index)
				gcab_pkg::REG_START_COLOR: start_color_q <= cfg_data;
				gcab_pkg::REG_MID_COLOR:   mid_color_q   <= cfg_data;
				gcab_pkg::REG_END_COLOR:   end_color_q   <= cfg_data;
				gcab_pkg::REG_DARK_LEVEL:  dark_level_q  <= cfg_data[7:0];
				gcab_pkg::REG_LIGHT_LEVEL: light_level_q <= cfg_data[7:0];
				gcab_pkg::REG_CHECK_MASK:  check_mask_q  <= cfg_data[7:0];
				gcab_pkg::REG_AREA_WIDTH:  area_width_q  <= cfg_data[WW-1:0];
				gcab_pkg::REG_USE_MAP:     use_map_q     <= cfg_data[0];
				default:                   use_map_q     <= use_map_q;
			endcase
		end
	end

	// Effective width, clamped to the widest supported bar.
	logic [WW-1:0] width_c;
	always_comb begin
		if ({4'd0, area_width_q} > 17'(MAX_WIDTH)) begin
			width_c = WW'(MAX_WIDTH);
		end else begin
			width_c = area_width_q;
		end
	end

	// Gradient and map steps.
	gcab_pkg::grad_step_t grad;
	logic [SW-1:0]        map_step;
	logic                 coef_ready;

	gcab_coef #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_write),
		.start_color(start_color_q),
		.mid_color  (mid_color_q),
		.end_color  (end_color_q),
		.width      (width_c),
		.grad       (grad),
		.map_step   (map_step),
		.ready      (coef_ready)
	);

	// Stage enables: a stage moves on when the next one is empty or moving.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4, en_out;

	assign en_out   = !out_valid || out_ready;
	assign en_s4    = !v_s4 || en_out;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1 && coef_ready && !cfg_write;

	// Decode of the incoming item: segment, offset, range and background.
	logic [CLW-1:0] half_c, k_c;
	logic           width_err_c, seg_c, in_bar_c, idx_ok_c, keep_c;
	logic [7:0]     bg_c;

	always_comb begin
		half_c      = width_c[WW-1:1];
		width_err_c = (width_c < WW'(2));
		seg_c       = (column >= half_c);
		k_c         = seg_c ? (column - half_c) : column;
		if (width_err_c) begin
			in_bar_c = 1'b1;
		end else if (use_map_q) begin
			in_bar_c = ({1'b0, column} < width_c);
		end else begin
			in_bar_c = ({1'b0, column} < {half_c, 1'b0});
		end
		idx_ok_c = (32'(entry_index) < 32'(TABLE_DEPTH));
		keep_c   = (opcode == gcab_pkg::OP_RENDER) ? in_bar_c : idx_ok_c;
		if (((column[7:0] ^ row[7:0]) & check_mask_q) != 8'd0) begin
			bg_c = dark_level_q;
		end else begin
			bg_c = light_level_q;
		end
	end

	// Stage 1 registers.
	logic           wr_s1, err_s1, seg_s1;
	logic [CLW-1:0] k_s1, col_s1;
	logic [7:0]     bg_s1;
	logic [AW-1:0]  idx_s1;
	logic [31:0]    rgba_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid && in_ready && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			wr_s1   <= (opcode == gcab_pkg::OP_WRITE);
			err_s1  <= width_err_c;
			seg_s1  <= seg_c;
			k_s1    <= k_c;
			col_s1  <= column;
			bg_s1   <= bg_c;
			idx_s1  <= AW'(entry_index);
			rgba_s1 <= entry_rgba;
		end
	end

	// Stage 1 work: gradient offset times step per channel, and the map
	// position product split into a low and a high partial product.
	logic [3:0][TW-1:0] prod_c;
	logic [PLW-1:0]     plo_c;
	logic [PHW-1:0]     phi_c;

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			prod_c[ch] = TW'(k_s1) * (seg_s1 ? grad.hi[ch] : grad.lo[ch]);
		end
		plo_c = PLW'(col_s1) * PLW'(map_step[15:0]);
		phi_c = PHW'(col_s1) * PHW'(map_step[SW-1:16]);
	end

	// Stage 2 registers.
	logic               wr_s2, err_s2, seg_s2;
	logic [7:0]         bg_s2;
	logic [AW-1:0]      idx_s2;
	logic [31:0]        rgba_s2;
	logic [3:0][TW-1:0] prod_s2;
	logic [PLW-1:0]     plo_s2;
	logic [PHW-1:0]     phi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			wr_s2   <= wr_s1;
			err_s2  <= err_s1;
			seg_s2  <= seg_s1;
			bg_s2   <= bg_s1;
			idx_s2  <= idx_s1;
			rgba_s2 <= rgba_s1;
			prod_s2 <= prod_c;
			plo_s2  <= plo_c;
			phi_s2  <= phi_c;
		end
	end

	// Stage 2 work: gradient colour from base plus product, and the map
	// position. The foreground byte is the integer part of the 8.16 value.
	logic [3:0][7:0] fgg_c;
	logic [TW-1:0]   sum_c;
	logic [AW-1:0]   pos_c;

	always_comb begin
		sum_c = '0;
		for (int ch = 0; ch < 4; ch++) begin
			sum_c = {gcab_pkg::byte_of(seg_s2 ? mid_color_q : start_color_q, 2'(ch)), 16'h0000}
				+ prod_s2[ch];
			fgg_c[ch] = sum_c[23:16];
		end
		pos_c = AW'(phi_s2 + PHW'(plo_s2[PLW-1:16]));
	end

	// Colour map: written and read by the item leaving stage 2, so writes
	// and reads keep the order of the input transfers.
	logic [31:0] colour_mem [TABLE_DEPTH];
	logic [31:0] rd_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			if (v_s2 && wr_s2) begin
				colour_mem[idx_s2] <= rgba_s2;
			end
			rd_s3 <= colour_mem[pos_c];
		end
	end

	// Stage 3 registers; map writes end here.
	logic            err_s3;
	logic [7:0]      bg_s3;
	logic [3:0][7:0] fgg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2 && !wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			err_s3 <= err_s2;
			bg_s3  <= bg_s2;
			fgg_s3 <= fgg_c;
		end
	end

	// Stage 3 work: pick the foreground and multiply the difference to the
	// background by alpha, modulo 2^18.
	logic [3:0][7:0]  fg_c;
	logic [8:0]       dif_c;
	logic [2:0][17:0] p_c;

	always_comb begin
		dif_c = '0;
		for (int ch = 0; ch < 4; ch++) begin
			fg_c[ch] = use_map_q ? gcab_pkg::byte_of(rd_s3, 2'(ch)) : fgg_s3[ch];
		end
		for (int ch = 0; ch < 3; ch++) begin
			dif_c    = {1'b0, fg_c[ch]} - {1'b0, bg_s3};
			p_c[ch]  = {{9{dif_c[8]}}, dif_c} * {10'd0, fg_c[3]};
		end
	end

	// Stage 4 registers.
	logic             err_s4;
	logic [7:0]       bg_s4;
	logic [2:0][17:0] p_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			err_s4 <= err_s3;
			bg_s4  <= bg_s3;
			p_s4   <= p_c;
		end
	end

	// Stage 4 work: rounded division by 255 of the signed product, then
	// added back onto the background modulo 256.
	logic [23:0]     f_c;
	logic [15:0]     t_c;
	logic [2:0][7:0] o_c;

	always_comb begin
		f_c = '0;
		t_c = '0;
		for (int ch = 0; ch < 3; ch++) begin
			f_c      = {{6{p_s4[ch][17]}}, p_s4[ch]};
			t_c      = f_c[15:0] + f_c[23:8] + gcab_pkg::BLEND_ROUND;
			o_c[ch]  = err_s4 ? 8'd0 : (bg_s4 + t_c[15:8]);
		end
	end

	// Output register.
	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       width_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			red_q         <= o_c[0];
			green_q       <= o_c[1];
			blue_q        <= o_c[2];
			width_error_q <= err_s4;
		end
	end

	assign out_valid   = out_valid_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign width_error = width_error_q;

`ifndef SYNTHESIS
	// A configuration write holds off input transfers while steps are redone.
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !in_ready)
		else $error("input ready right after a configuration write");

	// Stage 1 fills only from an input transfer.
	a_s1_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(in_valid && in_ready))
		else $error("stage 1 filled without an input transfer");

	// A width error result carries a black pixel.
	a_error_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && width_error) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("width error result with a colour");

	// A new result in the output register comes from stage 4.
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s4))
		else $error("result appeared without an item in stage 4");
`endif

endmodule
